// ----- rtl/erc_pkg.sv -----
// types, codes and sizes shared by the expiring route cache
package erc_pkg;

  localparam int unsigned CacheEntries = 64;
  localparam int unsigned IdxW         = $clog2(CacheEntries);

  localparam logic [1:0] OP_LOOKUP_ANY    = 2'd0;
  localparam logic [1:0] OP_LOOKUP_TUNNEL = 2'd1;
  localparam logic [1:0] OP_INSERT        = 2'd2;
  localparam logic [1:0] OP_FLUSH         = 2'd3;

  localparam logic [15:0] ExpiryReset = 16'd600;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] tunnel_id;
    logic [31:0] lookup_address;
    logic [31:0] gateway_in;
    logic [31:0] now;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] gateway_out;
    logic [5:0]  slot;
  } out_t;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] gateway;
    logic [15:0] tunnel;
    logic [31:0] stamp;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

// ----- rtl/expiring_route_cache.sv -----
// top level of the expiring route cache: sequencer, live bits and config register
//
//  channel  | signals                                         | handshake
//  ---------+-------------------------------------------------+--------------------------
//  request  | start_i, busy_o, item_i                         | taken when start_i & !busy_o
//  result   | done_o, result_o                                | one-cycle strobe, no stall
//  config   | psel_i, penable_i, pwrite_i, paddr_i, pwdata_i, | apb, pready_o always high
//           | prdata_o, pready_o                              |
//
// lookups and flushes sweep all 64 entries through the table ram read port, one entry
// a cycle.
// an insert sweeps down from the top entry until it meets a free one, else it takes the
// oldest entry (higher index on a tie), and then writes the item into the picked entry.
// reset frees every entry at once through the live bits; no clearing pass is needed.
// the result strobe cannot be held off; the next item may start in the strobe cycle.
module expiring_route_cache
  import erc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  in_t         item_i,
  output logic        busy_o,
  output logic        done_o,
  output out_t        result_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(CacheEntries - 1);

  logic [1:0]              state_q, state_d;
  logic [15:0]             expiry_q;
  logic [CacheEntries-1:0] live_q, live_d;
  logic [IdxW-1:0]         issue_idx_q, issue_idx_d;
  logic                    issuing_q, issuing_d;
  logic                    pend_q, pend_d;
  logic [IdxW-1:0]         pend_idx_q, pend_idx_d;
  logic [IdxW-1:0]         pick_q, pick_d;
  logic [31:0]             best_q, best_d;
  logic                    have_best_q, have_best_d;
  logic                    done_q, done_d;
  in_t                     req_q, req_d;
  out_t                    res_q, res_d;

  logic                    ram_we, ram_re;
  entry_t                  ram_wdata, ram_rdata;
  logic [EntryW-1:0]       ram_rdata_raw;

  logic                    is_insert;
  logic                    expired;
  logic                    live_after;
  logic                    older;
  logic                    addr_match;
  logic                    tun_match;
  logic [IdxW-1:0]         end_idx;

  erc_ram #(
    .Width (EntryW),
    .Depth (CacheEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pick_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (issue_idx_q),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);
  assign ram_wdata = '{address: req_q.lookup_address, gateway: req_q.gateway_in,
                       tunnel: req_q.tunnel_id, stamp: req_q.now};

  // per-entry checks on the word read for pend_idx_q
  assign is_insert  = (req_q.operation == OP_INSERT);
  assign expired    = ({1'b0, ram_rdata.stamp} + {17'b0, expiry_q}) < {1'b0, req_q.now};
  assign live_after = live_q[pend_idx_q] & ~expired;
  assign older      = ram_rdata.stamp < best_q;
  assign addr_match = (ram_rdata.address == req_q.lookup_address);
  assign tun_match  = (ram_rdata.tunnel == req_q.tunnel_id);
  assign end_idx    = is_insert ? '0 : LastIdx;

  always_comb begin
    state_d     = state_q;
    live_d      = live_q;
    issue_idx_d = issue_idx_q;
    issuing_d   = issuing_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    pick_d      = pick_q;
    best_d      = best_q;
    have_best_d = have_best_q;
    done_d      = 1'b0;
    req_d       = req_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d       = item_i;
          res_d       = '0;
          issue_idx_d = (item_i.operation == OP_INSERT) ? LastIdx : '0;
          issuing_d   = 1'b1;
          have_best_d = 1'b0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ram_re     = issuing_q;
        pend_d     = issuing_q;
        pend_idx_d = issue_idx_q;
        if (issuing_q) begin
          if (issue_idx_q == end_idx) begin
            issuing_d = 1'b0;
          end else if (is_insert) begin
            issue_idx_d = issue_idx_q - 1'b1;
          end else begin
            issue_idx_d = issue_idx_q + 1'b1;
          end
        end
        if (pend_q) begin
          case (req_q.operation)
            OP_INSERT: begin
              if (expired) begin
                live_d[pend_idx_q] = 1'b0;
              end
              if (!live_after) begin
                // first free entry from the top ends the sweep
                pick_d    = pend_idx_q;
                issuing_d = 1'b0;
                pend_d    = 1'b0;
                state_d   = ST_WRITE;
              end else begin
                // strict compare: on a tie the higher index seen first stays
                if (!have_best_q || older) begin
                  best_d      = ram_rdata.stamp;
                  pick_d      = pend_idx_q;
                  have_best_d = 1'b1;
                end
                if (pend_idx_q == '0) begin
                  state_d = ST_WRITE;
                end
              end
            end
            OP_FLUSH: begin
              if (tun_match) begin
                live_d[pend_idx_q] = 1'b0;
              end
              if (pend_idx_q == LastIdx) begin
                done_d  = 1'b1;
                state_d = ST_IDLE;
              end
            end
            default: begin
              if (expired) begin
                live_d[pend_idx_q] = 1'b0;
              end
              if (live_after && addr_match && !res_q.hit &&
                  (req_q.operation == OP_LOOKUP_ANY || tun_match)) begin
                res_d.hit         = 1'b1;
                res_d.gateway_out = ram_rdata.gateway;
                res_d.slot        = 6'(pend_idx_q);
              end
              if (pend_idx_q == LastIdx) begin
                done_d  = 1'b1;
                state_d = ST_IDLE;
              end
            end
          endcase
        end
      end
      ST_WRITE: begin
        ram_we         = 1'b1;
        live_d[pick_q] = (req_q.now != '0);
        res_d.slot     = 6'(pick_q);
        done_d         = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      live_q      <= '0;
      issue_idx_q <= '0;
      issuing_q   <= 1'b0;
      pend_q      <= 1'b0;
      have_best_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      issue_idx_q <= issue_idx_d;
      issuing_q   <= issuing_d;
      pend_q      <= pend_d;
      have_best_q <= have_best_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    pend_idx_q <= pend_idx_d;
    pick_q     <= pick_d;
    best_q     <= best_d;
  end

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= ExpiryReset;
    end else if (psel_i && penable_i && pwrite_i && !paddr_i[2]) begin
      expiry_q <= pwdata_i[15:0];
    end
  end

  assign prdata_o = paddr_i[2] ? 32'd0 : {16'd0, expiry_q};
  assign pready_o = 1'b1;

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ----- rtl/erc_ram.sv -----
// generic ram, one write port and one registered read port
module erc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- tb/expiring_route_cache_tb.sv -----
// self-checking testbench for the expiring route cache: directed items, then random phases
`timescale 1ns / 100ps

import erc_pkg::*;

localparam logic [2:0] ExpiryAddr = 3'd0;
localparam logic [2:0] SpareAddr  = 3'd4;

class route_scoreboard;
  bit [31:0] route_addr   [CacheEntries];
  bit [31:0] route_gw     [CacheEntries];
  bit [15:0] route_tunnel [CacheEntries];
  bit [31:0] route_stamp  [CacheEntries];
  bit [15:0] expiry = ExpiryReset;
  out_t      expected_results [$];
  int        errors = 0;

  function void set_register(logic [2:0] addr, logic [31:0] data);
    if (addr == ExpiryAddr) expiry = data[15:0];
  endfunction

  // stamp plus expiry is summed on 33 bits, so late stamps never wrap
  function void age_route(int k, logic [31:0] now_s);
    if ({1'b0, route_stamp[k]} + {17'b0, expiry} < {1'b0, now_s}) route_stamp[k] = '0;
  endfunction

  function void note_item(in_t it);
    out_t        want;
    int          pick;
    logic [31:0] oldest;
    want = '0;
    case (it.operation)
      OP_LOOKUP_ANY, OP_LOOKUP_TUNNEL: begin
        for (int k = 0; k < CacheEntries; k++) age_route(k, it.now);
        for (int k = 0; k < CacheEntries; k++) begin
          if (route_stamp[k] != 0 && route_addr[k] == it.lookup_address &&
              (it.operation == OP_LOOKUP_ANY || route_tunnel[k] == it.tunnel_id)) begin
            want.hit = 1'b1;
            want.gateway_out = route_gw[k];
            want.slot = k[5:0];
            break;
          end
        end
      end
      OP_INSERT: begin
        // first free entry from the top, else the oldest one, highest index on a tie
        pick = -1;
        oldest = '0;
        for (int k = CacheEntries - 1; k >= 0; k--) begin
          age_route(k, it.now);
          if (route_stamp[k] == 0) begin
            pick = k;
            break;
          end
          if (pick < 0 || route_stamp[k] < oldest) begin
            oldest = route_stamp[k];
            pick = k;
          end
        end
        if (pick < 0) pick = 0;
        route_addr[pick] = it.lookup_address;
        route_gw[pick] = it.gateway_in;
        route_tunnel[pick] = it.tunnel_id;
        route_stamp[pick] = it.now;
        want.slot = pick[5:0];
      end
      default: begin
        for (int k = 0; k < CacheEntries; k++)
          if (route_tunnel[k] == it.tunnel_id) route_stamp[k] = '0;
      end
    endcase
    expected_results.push_back(want);
  endfunction

  function void report(string field, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("%0t: %s expected %h got %h", $time, field, want, got);
  endfunction

  function void check_result(out_t got);
    out_t want;
    if (expected_results.size() == 0) begin
      report("result with no item waiting, result", '0, {25'b0, got.hit, got.slot});
      return;
    end
    want = expected_results.pop_front();
    if (got.hit !== want.hit) report("hit", {31'b0, want.hit}, {31'b0, got.hit});
    if (got.gateway_out !== want.gateway_out)
      report("gateway_out", want.gateway_out, got.gateway_out);
    if (got.slot !== want.slot) report("slot", {26'b0, want.slot}, {26'b0, got.slot});
  endfunction
endclass

module expiring_route_cache_tb;

  localparam int QuietLimit = 4000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  in_t         item;
  logic        busy;
  logic        done;
  out_t        result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  route_scoreboard sb = new;

  logic [31:0] now_s;
  logic [31:0] addr_pool [16];
  logic [15:0] tunnel_pool [4];
  int          quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  expiring_route_cache i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .start_i   (start),
    .item_i    (item),
    .busy_o    (busy),
    .done_o    (done),
    .result_o  (result),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready)
  );

  always @(posedge clk) begin
    if (rst_n && done) sb.check_result(result);
  end

  // ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_t route_op(logic [1:0] op, logic [15:0] tun, logic [31:0] addr,
                                   logic [31:0] gw, logic [31:0] when);
    in_t it;
    it.operation = op;
    it.tunnel_id = tun;
    it.lookup_address = addr;
    it.gateway_in = gw;
    it.now = when;
    return it;
  endfunction

  task automatic send_item(in_t it);
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
  endtask

  task automatic hold_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(addr, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_expiry();
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    paddr <= ExpiryAddr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got[15:0] !== sb.expiry) sb.report("expiry_seconds", {16'b0, sb.expiry}, got);
    @(posedge clk);
  endtask

  task automatic run_phase(logic [15:0] expiry_val, int idle_pct, int count);
    in_t it;
    int  pick;
    int  step_max;
    wait_drained();
    apb_write(ExpiryAddr, {16'($urandom), expiry_val});
    check_expiry();
    // small time steps keep entries alive long enough to fill the table
    step_max = expiry_val / 128 + 1;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      it.operation = (pick < 40) ? OP_INSERT :
                     (pick < 65) ? OP_LOOKUP_TUNNEL :
                     (pick < 95) ? OP_LOOKUP_ANY : OP_FLUSH;
      it.tunnel_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                     tunnel_pool[$urandom_range(0, 3)];
      it.lookup_address = ($urandom_range(0, 9) == 0) ? $urandom :
                          addr_pool[$urandom_range(0, 15)];
      it.gateway_in = $urandom;
      pick = $urandom_range(0, 99);
      if (pick == 0) now_s = $urandom;
      else if (pick < 3) now_s = now_s + expiry_val + $urandom_range(1, 1000);
      else now_s = now_s + $urandom_range(0, step_max);
      if (now_s == 0) now_s = 1;
      it.now = now_s;
      send_item(it);
      if ($urandom_range(0, 99) < idle_pct) hold_sender($urandom_range(1, 80));
      else if ($urandom_range(0, 59) == 0) wait_drained();
    end
  endtask

  initial begin
    in_t directed_items [22];
    rst_n <= 1'b0;
    start <= 1'b0;
    item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (int i = 0; i < 16; i++) addr_pool[i] = $urandom;
    for (int i = 0; i < 4; i++) tunnel_pool[i] = 16'($urandom);
    now_s = 32'd2000;

    directed_items = '{
      route_op(OP_LOOKUP_ANY,    16'h0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'd1000),
      route_op(OP_INSERT,        16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'd1000),
      route_op(OP_INSERT,        16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'd1000),
      route_op(OP_INSERT,        16'h0005, 32'h0A00_0001, 32'h2C00_0001, 32'd1001),
      route_op(OP_INSERT,        16'h0006, 32'h0A00_0001, 32'h2C00_0002, 32'd1002),
      route_op(OP_LOOKUP_ANY,    16'h0007, 32'h0A00_0001, 32'h0000_0000, 32'd1010),
      route_op(OP_LOOKUP_TUNNEL, 16'h0005, 32'h0A00_0001, 32'h0000_0000, 32'd1010),
      route_op(OP_LOOKUP_TUNNEL, 16'h0007, 32'h0A00_0001, 32'h0000_0000, 32'd1010),
      route_op(OP_LOOKUP_TUNNEL, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'd1010),
      route_op(OP_LOOKUP_ANY,    16'h0000, 32'h0000_0000, 32'h0000_0000, 32'd1010),
      route_op(OP_FLUSH,         16'h0006, 32'h0000_0000, 32'h0000_0000, 32'd1010),
      route_op(OP_LOOKUP_ANY,    16'h0000, 32'h0A00_0001, 32'h0000_0000, 32'd1010),
      route_op(OP_INSERT,        16'h0008, 32'h0A00_0002, 32'h2C00_0003, 32'd1003),
      // stamp plus expiry equal to now is still live, one second later it is gone
      route_op(OP_LOOKUP_ANY,    16'h0000, 32'h0A00_0001, 32'h0000_0000, 32'd1601),
      route_op(OP_LOOKUP_ANY,    16'h0000, 32'h0A00_0001, 32'h0000_0000, 32'd1602),
      route_op(OP_FLUSH,         16'h0000, 32'h0000_0000, 32'h0000_0000, 32'd1602),
      // insert at time zero leaves the entry free
      route_op(OP_INSERT,        16'h0009, 32'h0A00_0003, 32'h2C00_0004, 32'd0),
      route_op(OP_LOOKUP_ANY,    16'h0009, 32'h0A00_0003, 32'h0000_0000, 32'd1602),
      // late stamp: the ageing sum must not wrap
      route_op(OP_INSERT,        16'h0003, 32'hC0A8_0001, 32'h2C00_0005, 32'hFFFF_FF00),
      route_op(OP_LOOKUP_TUNNEL, 16'h0003, 32'hC0A8_0001, 32'h0000_0000, 32'hFFFF_FFFF),
      route_op(OP_LOOKUP_ANY,    16'h0000, 32'hC0A8_0001, 32'h0000_0000, 32'd5),
      route_op(OP_FLUSH,         16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_expiry();

    foreach (directed_items[i]) send_item(directed_items[i]);
    wait_drained();
    // a write beyond the only register must change nothing
    apb_write(SpareAddr, 32'hFFFF_FFFF);

    run_phase(16'd65535, 0, 250);
    run_phase(16'd600, 59, 200);
    run_phase(16'd1, 24, 150);
    run_phase(16'd0, 0, 150);
    run_phase(16'd3000, 24, 250);
    run_phase(16'd65535, 59, 200);

    wait_drained();
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/erc_pkg.sv
rtl/erc_ram.sv
rtl/expiring_route_cache.sv
tb/expiring_route_cache_tb.sv
